/* src/dat_pkg.sv */
// dat_pkg: shared types, codes and reset values for the demand-actuated
// traffic light core. No dependencies.
package dat_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned DurW  = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] LIGHT_RED    = 2'd0;
  localparam logic [1:0] LIGHT_ORANGE = 2'd1;
  localparam logic [1:0] LIGHT_GREEN  = 2'd2;

  localparam logic [2:0] PH_V_GREEN        = 3'd0;
  localparam logic [2:0] PH_V_ORANGE_RED   = 3'd1;
  localparam logic [2:0] PH_H_ORANGE_GREEN = 3'd2;
  localparam logic [2:0] PH_H_GREEN        = 3'd3;
  localparam logic [2:0] PH_H_ORANGE_RED   = 3'd4;
  localparam logic [2:0] PH_V_ORANGE_GREEN = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_ORANGE_TIME = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_GREEN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_RED     = 2'd2;

  localparam logic [DurW-1:0] ORANGE_TIME_RST = 16'd2000;
  localparam logic [DurW-1:0] IDLE_GREEN_RST  = 16'd5000;
  localparam logic [DurW-1:0] MAX_RED_RST     = 16'd6000;

  typedef enum logic [5:0] {
    ST_V_GREEN        = 6'b000001,
    ST_V_ORANGE_RED   = 6'b000010,
    ST_H_ORANGE_GREEN = 6'b000100,
    ST_H_GREEN        = 6'b001000,
    ST_H_ORANGE_RED   = 6'b010000,
    ST_V_ORANGE_GREEN = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             cars_horizontal;
    logic             cars_vertical;
  } in_req_t;

  typedef struct packed {
    logic [1:0] vertical_light;
    logic [1:0] horizontal_light;
    logic [2:0] current_phase;
  } out_req_t;

endpackage

/* src/demand_actuated_traffic_light_core.sv */
// demand_actuated_traffic_light_core: six-phase two-road signal controller
// with input register, phase update logic and result register. Uses dat_pkg.
//
// channel | direction | handshake           | payload
// in_     | input     | in_valid / in_stall | dat_pkg::in_req_t
// out_    | output    | out_valid/out_stall | dat_pkg::out_req_t
// cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// an accepted request waits in the input register, then moves into the
// result register unless out_stall is holding that register
// one request per cycle is sustained while out_stall is low; the phase update
// is a single pass of two 32-bit subtracts and three compares
// synchronous active-low reset restores vertical green and default timings
// out_stall holds the result register; in_stall rises once the input
// register is also full
module demand_actuated_traffic_light_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  dat_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output dat_pkg::out_req_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dat_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dat_pkg::DurW-1:0]      cfg_data
);

  logic [dat_pkg::DurW-1:0]  orange_time_r;
  logic [dat_pkg::DurW-1:0]  idle_green_r;
  logic [dat_pkg::DurW-1:0]  max_red_r;

  dat_pkg::phase_t           phase_r, phase_nxt;
  logic [dat_pkg::TimeW-1:0] green_start_r, green_start_nxt;
  logic [dat_pkg::TimeW-1:0] orange_start_r, orange_start_nxt;

  logic                      s1_valid_r;
  dat_pkg::in_req_t          s1_req_r;
  logic                      out_valid_r;
  dat_pkg::out_req_t         out_req_r, out_req_nxt;

  logic                      advance;
  logic                      in_accept;
  logic [dat_pkg::TimeW-1:0] green_el;
  logic [dat_pkg::TimeW-1:0] orange_el;
  logic                      orange_done;
  logic                      idle_done;
  logic                      max_done;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_req_r;

  assign green_el    = s1_req_r.now_ms - green_start_r;
  assign orange_el   = s1_req_r.now_ms - orange_start_r;
  assign orange_done = orange_el >= {{(dat_pkg::TimeW-dat_pkg::DurW){1'b0}}, orange_time_r};
  assign idle_done   = green_el >= {{(dat_pkg::TimeW-dat_pkg::DurW){1'b0}}, idle_green_r};
  assign max_done    = green_el >= {{(dat_pkg::TimeW-dat_pkg::DurW){1'b0}}, max_red_r};

  function automatic logic hand_over(input logic mine, input logic other,
                                     input logic idle_ok, input logic max_ok);
    logic r;
    r = (!mine && !other && idle_ok) || (mine && other && max_ok) || (other && !mine);
    return r;
  endfunction

  always_comb begin
    phase_nxt        = phase_r;
    green_start_nxt  = green_start_r;
    orange_start_nxt = orange_start_r;
    out_req_nxt.vertical_light   = dat_pkg::LIGHT_RED;
    out_req_nxt.horizontal_light = dat_pkg::LIGHT_RED;
    out_req_nxt.current_phase    = dat_pkg::PH_V_GREEN;
    case (phase_r)
      dat_pkg::ST_V_GREEN: begin
        out_req_nxt.vertical_light = dat_pkg::LIGHT_GREEN;
        out_req_nxt.current_phase  = dat_pkg::PH_V_GREEN;
        if (hand_over(s1_req_r.cars_vertical, s1_req_r.cars_horizontal,
                      idle_done, max_done)) begin
          orange_start_nxt = s1_req_r.now_ms;
          phase_nxt        = dat_pkg::ST_V_ORANGE_RED;
        end
      end
      dat_pkg::ST_V_ORANGE_RED: begin
        out_req_nxt.vertical_light = dat_pkg::LIGHT_ORANGE;
        out_req_nxt.current_phase  = dat_pkg::PH_V_ORANGE_RED;
        if (orange_done) begin
          orange_start_nxt = s1_req_r.now_ms;
          phase_nxt        = dat_pkg::ST_H_ORANGE_GREEN;
        end
      end
      dat_pkg::ST_H_ORANGE_GREEN: begin
        out_req_nxt.horizontal_light = dat_pkg::LIGHT_ORANGE;
        out_req_nxt.current_phase    = dat_pkg::PH_H_ORANGE_GREEN;
        if (orange_done) begin
          green_start_nxt = s1_req_r.now_ms;
          phase_nxt       = dat_pkg::ST_H_GREEN;
        end
      end
      dat_pkg::ST_H_GREEN: begin
        out_req_nxt.horizontal_light = dat_pkg::LIGHT_GREEN;
        out_req_nxt.current_phase    = dat_pkg::PH_H_GREEN;
        if (hand_over(s1_req_r.cars_horizontal, s1_req_r.cars_vertical,
                      idle_done, max_done)) begin
          orange_start_nxt = s1_req_r.now_ms;
          phase_nxt        = dat_pkg::ST_H_ORANGE_RED;
        end
      end
      dat_pkg::ST_H_ORANGE_RED: begin
        out_req_nxt.horizontal_light = dat_pkg::LIGHT_ORANGE;
        out_req_nxt.current_phase    = dat_pkg::PH_H_ORANGE_RED;
        if (orange_done) begin
          orange_start_nxt = s1_req_r.now_ms;
          phase_nxt        = dat_pkg::ST_V_ORANGE_GREEN;
        end
      end
      dat_pkg::ST_V_ORANGE_GREEN: begin
        out_req_nxt.vertical_light = dat_pkg::LIGHT_ORANGE;
        out_req_nxt.current_phase  = dat_pkg::PH_V_ORANGE_GREEN;
        if (orange_done) begin
          green_start_nxt = s1_req_r.now_ms;
          phase_nxt       = dat_pkg::ST_V_GREEN;
        end
      end
      default: begin
        phase_nxt = dat_pkg::ST_V_GREEN;
      end
    endcase
  end

  // control and state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      phase_r        <= dat_pkg::ST_V_GREEN;
      green_start_r  <= '0;
      orange_start_r <= '0;
      orange_time_r  <= dat_pkg::ORANGE_TIME_RST;
      idle_green_r   <= dat_pkg::IDLE_GREEN_RST;
      max_red_r      <= dat_pkg::MAX_RED_RST;
    end else begin
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      s1_valid_r <= in_accept || (s1_valid_r && !advance);
      if (advance && s1_valid_r) begin
        phase_r        <= phase_nxt;
        green_start_r  <= green_start_nxt;
        orange_start_r <= orange_start_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dat_pkg::CFG_ORANGE_TIME: orange_time_r <= cfg_data;
          dat_pkg::CFG_IDLE_GREEN:  idle_green_r  <= cfg_data;
          dat_pkg::CFG_MAX_RED:     max_red_r     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_r <= in_data;
    end
    if (advance && s1_valid_r) begin
      out_req_r <= out_req_nxt;
    end
  end

endmodule

/* tb/sv/demand_actuated_traffic_light_core_tb.sv */
`timescale 1ns / 100ps
// demand_actuated_traffic_light_core_tb: self-checking bench for the two-road signal
// core; predicts the lights of every request and checks results in order.
// Depends on dat_pkg and demand_actuated_traffic_light_core.
module demand_actuated_traffic_light_core_tb;

  localparam logic [dat_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_MAX = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dat_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dat_pkg::out_req_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dat_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [dat_pkg::DurW-1:0] cfg_data = '0;

  // predicted controller state and timing
  logic [dat_pkg::DurW-1:0] orange_ms, idle_green_ms, max_red_ms;
  logic [2:0] ph_q;
  logic [dat_pkg::TimeW-1:0] green_t0, orange_t0;
  dat_pkg::out_req_t lights_due[$];

  int unsigned snd_idle_pct = 27;
  int unsigned rcv_stall_pct = 84;
  int unsigned n_req = 0;
  int unsigned n_res = 0;
  int unsigned n_cfg = 0;
  int unsigned n_bad = 0;
  int unsigned quiet_cycles = 0;
  logic [dat_pkg::TimeW-1:0] wall_ms = '0;

  demand_actuated_traffic_light_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic span_done(logic [dat_pkg::TimeW-1:0] now,
                                     logic [dat_pkg::TimeW-1:0] t0,
                                     logic [dat_pkg::DurW-1:0] span);
    logic [dat_pkg::TimeW-1:0] dt;
    dt = now - t0;
    return dt >= span;
  endfunction

  function automatic logic green_yields(logic [dat_pkg::TimeW-1:0] now, logic mine,
                                        logic other);
    return (!mine && !other && span_done(now, green_t0, idle_green_ms)) ||
           (mine && other && span_done(now, green_t0, max_red_ms)) ||
           (other && !mine);
  endfunction

  function automatic dat_pkg::out_req_t signal_step(dat_pkg::in_req_t r);
    dat_pkg::out_req_t o;
    o.vertical_light = dat_pkg::LIGHT_RED;
    o.horizontal_light = dat_pkg::LIGHT_RED;
    o.current_phase = ph_q;
    case (ph_q)
      dat_pkg::PH_V_GREEN: begin
        o.vertical_light = dat_pkg::LIGHT_GREEN;
        if (green_yields(r.now_ms, r.cars_vertical, r.cars_horizontal)) begin
          orange_t0 = r.now_ms;
          ph_q = dat_pkg::PH_V_ORANGE_RED;
        end
      end
      dat_pkg::PH_V_ORANGE_RED: begin
        o.vertical_light = dat_pkg::LIGHT_ORANGE;
        if (span_done(r.now_ms, orange_t0, orange_ms)) begin
          orange_t0 = r.now_ms;
          ph_q = dat_pkg::PH_H_ORANGE_GREEN;
        end
      end
      dat_pkg::PH_H_ORANGE_GREEN: begin
        o.horizontal_light = dat_pkg::LIGHT_ORANGE;
        if (span_done(r.now_ms, orange_t0, orange_ms)) begin
          green_t0 = r.now_ms;
          ph_q = dat_pkg::PH_H_GREEN;
        end
      end
      dat_pkg::PH_H_GREEN: begin
        o.horizontal_light = dat_pkg::LIGHT_GREEN;
        if (green_yields(r.now_ms, r.cars_horizontal, r.cars_vertical)) begin
          orange_t0 = r.now_ms;
          ph_q = dat_pkg::PH_H_ORANGE_RED;
        end
      end
      dat_pkg::PH_H_ORANGE_RED: begin
        o.horizontal_light = dat_pkg::LIGHT_ORANGE;
        if (span_done(r.now_ms, orange_t0, orange_ms)) begin
          orange_t0 = r.now_ms;
          ph_q = dat_pkg::PH_V_ORANGE_GREEN;
        end
      end
      dat_pkg::PH_V_ORANGE_GREEN: begin
        o.vertical_light = dat_pkg::LIGHT_ORANGE;
        if (span_done(r.now_ms, orange_t0, orange_ms)) begin
          green_t0 = r.now_ms;
          ph_q = dat_pkg::PH_V_GREEN;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin : monitor
    dat_pkg::out_req_t want;
    if (!rst_n) begin
      orange_ms = dat_pkg::ORANGE_TIME_RST;
      idle_green_ms = dat_pkg::IDLE_GREEN_RST;
      max_red_ms = dat_pkg::MAX_RED_RST;
      ph_q = dat_pkg::PH_V_GREEN;
      green_t0 = '0;
      orange_t0 = '0;
      lights_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        n_res++;
        if (lights_due.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("%0t: result with no request pending: v=%0d h=%0d phase=%0d", $time,
                     out_data.vertical_light, out_data.horizontal_light,
                     out_data.current_phase);
        end else begin
          want = lights_due.pop_front();
          if (out_data.vertical_light !== want.vertical_light ||
              out_data.horizontal_light !== want.horizontal_light ||
              out_data.current_phase !== want.current_phase) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("%0t: result %0d expected v=%0d h=%0d phase=%0d, got v=%0d h=%0d phase=%0d",
                       $time, n_res, want.vertical_light, want.horizontal_light,
                       want.current_phase, out_data.vertical_light,
                       out_data.horizontal_light, out_data.current_phase);
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_req++;
        lights_due.push_back(signal_step(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg++;
        case (cfg_index)
          dat_pkg::CFG_ORANGE_TIME: orange_ms = cfg_data;
          dat_pkg::CFG_IDLE_GREEN:  idle_green_ms = cfg_data;
          dat_pkg::CFG_MAX_RED:     max_red_ms = cfg_data;
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, lights_due.size());
      $display("demand_actuated_traffic_light_core_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  task automatic send_req(input logic [dat_pkg::TimeW-1:0] now, input logic ch,
                          input logic cv);
    dat_pkg::in_req_t r;
    r.now_ms = now;
    r.cars_horizontal = ch;
    r.cars_vertical = cv;
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // hold off new requests until every pending result is back
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (lights_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dat_pkg::CfgIdxW-1:0] idx,
                           input logic [dat_pkg::DurW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(input logic [dat_pkg::DurW-1:0] orange,
                            input logic [dat_pkg::DurW-1:0] idle,
                            input logic [dat_pkg::DurW-1:0] max_red);
    write_reg(dat_pkg::CFG_ORANGE_TIME, orange);
    write_reg(dat_pkg::CFG_IDLE_GREEN, idle);
    write_reg(dat_pkg::CFG_MAX_RED, max_red);
  endtask

  function automatic logic [dat_pkg::DurW-1:0] pick_span();
    logic [dat_pkg::DurW-1:0] v;
    v = 16'($urandom());
    case ($urandom_range(4))
      0: v = '0;
      1: v = '1;
      2: v = v % 41;
      3: v = 16'd1000 + v % 7000;
      default: ;
    endcase
    return v;
  endfunction

  // mostly forward-moving time, aimed at the current phase's deadline
  function automatic logic [dat_pkg::TimeW-1:0] pick_stamp();
    logic [dat_pkg::TimeW-1:0] t0;
    logic [dat_pkg::DurW-1:0] span;
    int unsigned sel;
    sel = $urandom_range(99);
    if (ph_q == dat_pkg::PH_V_GREEN || ph_q == dat_pkg::PH_H_GREEN) begin
      t0 = green_t0;
      span = ($urandom_range(1) != 0) ? idle_green_ms : max_red_ms;
    end else begin
      t0 = orange_t0;
      span = orange_ms;
    end
    if (sel < 6)
      wall_ms = $urandom();
    else if (sel < 40)
      wall_ms = t0 + span + $urandom_range(2) - 1;
    else
      wall_ms = wall_ms + $urandom_range(span / 2 + 1);
    return wall_ms;
  endfunction

  task automatic test_default_timing();
    send_req(32'd0, 1'b0, 1'b0);
    send_req(32'd4999, 1'b0, 1'b0);
    send_req(32'd5000, 1'b0, 1'b0);
    send_req(32'd7000, 1'b1, 1'b1);
    send_req(32'd9000, 1'b0, 1'b0);
    send_req(32'd9001, 1'b1, 1'b0);
    send_req(32'd14999, 1'b1, 1'b1);
    send_req(32'd15000, 1'b1, 1'b1);
    send_req(32'd17000, 1'b0, 1'b1);
    send_req(32'd19000, 1'b0, 1'b0);
    send_req(32'd19000, 1'b1, 1'b0);
    send_req(32'd21000, 1'b0, 1'b0);
    send_req(32'd23000, 1'b0, 1'b0);
    send_req(32'd23000, 1'b0, 1'b1);
  endtask

  task automatic test_wrap_and_backstep();
    send_req(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_req(32'd1998, 1'b1, 1'b1);
    send_req(32'd1999, 1'b1, 1'b1);
    // timestamp going backwards reads as a long green
    send_req(32'd1000, 1'b1, 1'b1);
  endtask

  task automatic test_zero_and_max_durations();
    wait_quiet();
    set_timing('0, '0, '0);
    write_reg(CFG_SPARE, '1);
    repeat (6) send_req(32'h8000_0000, 1'b1, 1'b1);
    wait_quiet();
    set_timing('1, '1, '1);
    send_req(32'h8000_0000 + 32'd65534, 1'b0, 1'b0);
    send_req(32'h8000_0000 + 32'd65535, 1'b0, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned snd,
                                     input int unsigned rcv);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        wait_quiet();
        set_timing(pick_span(), pick_span(), pick_span());
        if ($urandom_range(3) == 0) write_reg(CFG_SPARE, pick_span());
      end
      send_req(pick_stamp(), 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    wait_quiet();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_timing();
    test_wrap_and_backstep();
    test_zero_and_max_durations();
    wait_quiet();
    set_timing(dat_pkg::ORANGE_TIME_RST, dat_pkg::IDLE_GREEN_RST, dat_pkg::MAX_RED_RST);
    test_random_traffic(445, 27, 84);
    test_random_traffic(445, 84, 27);
    test_random_traffic(445, 0, 0);
    repeat (4) @(posedge clk);
    if (lights_due.size() != 0) begin
      $display("%0d results never arrived", lights_due.size());
      n_bad += lights_due.size();
    end
    $display("checked %0d signal results from %0d requests, %0d register writes",
             n_res, n_req, n_cfg);
    $display("zero, default, full-scale and random timings under three pacing mixes");
    if (n_bad == 0)
      $display("demand_actuated_traffic_light_core_tb: done, clean");
    else
      $display("demand_actuated_traffic_light_core_tb: done, errors");
    $finish;
  end

endmodule

/* files.f */
src/dat_pkg.sv
src/demand_actuated_traffic_light_core.sv
tb/sv/demand_actuated_traffic_light_core_tb.sv
